/* rtl/rmq_pkg.sv */
// shared constants and types for the rotation matrix to quaternion pipeline
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;

    // sideband that travels with each component lane
    typedef struct packed {
        logic flag;
        logic neg;
    } lane_tag_t;

endpackage

/* rtl/rmq_front.sv */
// branch selection, radicand and pair sums, registered
module rmq_front #(
    parameter int W = rmq_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [W-1:0]            e00,
    input  logic signed [W-1:0]            e01,
    input  logic signed [W-1:0]            e02,
    input  logic signed [W-1:0]            e10,
    input  logic signed [W-1:0]            e11,
    input  logic signed [W-1:0]            e12,
    input  logic signed [W-1:0]            e20,
    input  logic signed [W-1:0]            e21,
    input  logic signed [W-1:0]            e22,
    output logic                           out_valid,
    output logic [W:0]                     s_out,
    output logic [3:0][W:0]                v_out,
    output rmq_pkg::lane_tag_t [3:0]       tag_out
);
    import rmq_pkg::*;

    localparam int XW = W + 3;
    localparam logic signed [XW-1:0] ONE = XW'(1) <<< (W - 2);

    logic signed [XW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [XW-1:0] d, a, s_full;
    logic signed [XW-1:0] pr [4];
    logic signed [XW-1:0] mag;
    logic                 flag;

    logic                 valid_reg;
    logic [W:0]           s_reg;
    logic [3:0][W:0]      v_reg;
    lane_tag_t [3:0]      tag_reg;
    logic [3:0][W:0]      v_next;
    lane_tag_t [3:0]      tag_next;

    always_comb
    begin
        m00 = XW'(e00); m01 = XW'(e01); m02 = XW'(e02);
        m10 = XW'(e10); m11 = XW'(e11); m12 = XW'(e12);
        m20 = XW'(e20); m21 = XW'(e21); m22 = XW'(e22);
        d = m11 - m00;
        a = m11 + m00;
        case ({(m22 > 0), ((m22 > 0) ? (a > 0) : (d > 0))})
            2'b00:
            begin
                s_full = ONE - m22 - d;
                pr[0] = s_full;    pr[1] = m01 + m10;
                pr[2] = m02 + m20; pr[3] = m12 - m21;
            end
            2'b01:
            begin
                s_full = ONE - m22 + d;
                pr[0] = m01 + m10; pr[1] = s_full;
                pr[2] = m12 + m21; pr[3] = m20 - m02;
            end
            2'b10:
            begin
                s_full = ONE + m22 - a;
                pr[0] = m02 + m20; pr[1] = m12 + m21;
                pr[2] = s_full;    pr[3] = m01 - m10;
            end
            default:
            begin
                s_full = ONE + m22 + a;
                pr[0] = m12 - m21; pr[1] = m20 - m02;
                pr[2] = m01 - m10; pr[3] = s_full;
            end
        endcase
        flag = (s_full <= 0);
        for (int i = 0; i < 4; i++)
        begin
            mag = (pr[i] < 0) ? -pr[i] : pr[i];
            v_next[i] = mag[W:0];
            tag_next[i].flag = flag;
            tag_next[i].neg = (pr[i] < 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_full[W:0];
        v_reg   <= v_next;
        tag_reg <= tag_next;
    end

    assign out_valid = valid_reg;
    assign s_out     = s_reg;
    assign v_out     = v_reg;
    assign tag_out   = tag_reg;

endmodule

/* rtl/rmq_div.sv */
// square then restoring divide, one quotient bit per stage, saturating quotient
module rmq_div #(
    parameter int W = rmq_pkg::DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  rmq_pkg::lane_tag_t     in_tag,
    input  logic [W:0]             v,
    input  logic [W:0]             s,
    output logic                   out_valid,
    output rmq_pkg::lane_tag_t     out_tag,
    output logic [2*W:0]           q
);
    import rmq_pkg::*;

    localparam int QB = 2 * W + 1;
    localparam int NW = 3 * W;
    localparam int F  = W - 2;

    // square stage
    logic              sq_valid_reg;
    lane_tag_t         sq_tag_reg;
    logic [2*W+1:0]    sq_reg;
    logic [W:0]        sq_s_reg;

    logic [NW-1:0]     num;
    logic              ovf;

    // divide stages, index 0 is the setup stage
    logic              valid_reg [QB+1];
    lane_tag_t         tag_reg   [QB+1];
    logic [W:0]        s_reg     [QB+1];
    logic [W:0]        rem_reg   [QB+1];
    logic [QB-1:0]     low_reg   [QB+1];
    logic [QB-1:0]     quot_reg  [QB+1];
    logic              ovf_reg   [QB+1];

    assign num = {sq_reg, {F{1'b0}}};
    // quotient does not fit in QB bits when the upper part reaches s
    assign ovf = ({2'b00, num[NW-1:QB]} >= sq_s_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            sq_valid_reg <= in_valid;
            valid_reg[0] <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_tag_reg  <= in_tag;
        sq_reg      <= v * v;
        sq_s_reg    <= s;
        tag_reg[0]  <= sq_tag_reg;
        s_reg[0]    <= sq_s_reg;
        rem_reg[0]  <= {2'b00, num[NW-1:QB]};
        low_reg[0]  <= num[QB-1:0];
        quot_reg[0] <= '0;
        ovf_reg[0]  <= ovf;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        logic [W+1:0] r2;
        logic [W+1:0] diff;
        logic         take;

        assign r2   = {rem_reg[k], low_reg[k][QB-1]};
        assign diff = r2 - {1'b0, s_reg[k]};
        assign take = (r2 >= {1'b0, s_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k+1]  <= tag_reg[k];
            s_reg[k+1]    <= s_reg[k];
            rem_reg[k+1]  <= take ? diff[W:0] : r2[W:0];
            low_reg[k+1]  <= {low_reg[k][QB-2:0], 1'b0};
            quot_reg[k+1] <= {quot_reg[k][QB-2:0], take};
            ovf_reg[k+1]  <= ovf_reg[k];
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_tag   = tag_reg[QB];
    assign q         = ovf_reg[QB] ? {QB{1'b1}} : quot_reg[QB];

endmodule

/* rtl/rmq_sqrt.sv */
// digit-by-digit integer square root, one root bit per stage
module rmq_sqrt #(
    parameter int W = rmq_pkg::DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  rmq_pkg::lane_tag_t     in_tag,
    input  logic [2*W:0]           x,
    output logic                   out_valid,
    output rmq_pkg::lane_tag_t     out_tag,
    output logic [W:0]             root
);
    import rmq_pkg::*;

    localparam int NS = W + 1;
    localparam int XW = 2 * NS;

    logic              valid_reg [NS+1];
    lane_tag_t         tag_reg   [NS+1];
    logic [W:0]        rem_reg   [NS+1];
    logic [W:0]        root_reg  [NS+1];
    logic [XW-1:0]     x_reg     [NS+1];

    assign valid_reg[0] = in_valid;
    assign tag_reg[0]   = in_tag;
    assign rem_reg[0]   = '0;
    assign root_reg[0]  = '0;
    assign x_reg[0]     = {1'b0, x};

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        logic [W+2:0] r2;
        logic [W+2:0] trial;
        logic [W+2:0] diff;
        logic         take;

        assign r2    = {rem_reg[k], x_reg[k][XW-1:XW-2]};
        assign trial = {root_reg[k], 2'b01};
        assign diff  = r2 - trial;
        assign take  = (r2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k+1]  <= tag_reg[k];
            rem_reg[k+1]  <= take ? diff[W:0] : r2[W:0];
            root_reg[k+1] <= {root_reg[k][W-1:0], take};
            x_reg[k+1]    <= {x_reg[k][XW-3:0], 2'b00};
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_tag   = tag_reg[NS];
    assign root      = root_reg[NS];

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// top level: rotation matrix to quaternion, fully pipelined
// usage
//   command channel: drive the nine matrix elements e00..e22 (signed q2.f,
//   f = DATA_WIDTH-2) and pulse start; a word is taken at every rising edge
//   with start high and busy low. busy is always low, so a new matrix may
//   enter on every cycle.
//   result channel: done is high for exactly one cycle with quat_x, quat_y,
//   quat_z, quat_w and degenerate; the receiver must take the word then,
//   since it cannot hold results off.
//   pipeline: front end, then the restoring divider (square and setup stages,
//   then one quotient bit per stage, 2*DATA_WIDTH+1 stages), then the root
//   extractor (DATA_WIDTH+1 stages) and the output register.
//   throughput: one word per cycle.
//   reset: rst_n clears every valid bit, so nothing is in flight afterwards.
//   each lane computes round(|p|/(2*sqrt(s))) as (isqrt(floor(p*p*2^f/s))+1)/2;
//   the dominant lane uses p = s, which reduces to round(sqrt(s)/2)
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] e00,
    input  logic signed [DATA_WIDTH-1:0] e01,
    input  logic signed [DATA_WIDTH-1:0] e02,
    input  logic signed [DATA_WIDTH-1:0] e10,
    input  logic signed [DATA_WIDTH-1:0] e11,
    input  logic signed [DATA_WIDTH-1:0] e12,
    input  logic signed [DATA_WIDTH-1:0] e20,
    input  logic signed [DATA_WIDTH-1:0] e21,
    input  logic signed [DATA_WIDTH-1:0] e22,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quat_x,
    output logic signed [DATA_WIDTH-1:0] quat_y,
    output logic signed [DATA_WIDTH-1:0] quat_z,
    output logic signed [DATA_WIDTH-1:0] quat_w,
    output logic                         degenerate
);
    import rmq_pkg::*;

    localparam int W = DATA_WIDTH;
    // largest positive magnitude, and magnitude of the most negative code
    localparam logic [W:0] POS_MAX = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0] NEG_MAX = {2'b01, {(W-1){1'b0}}};

    // front end: branch select, radicand s and pair sums
    logic               f_valid;
    logic [W:0]         f_s;
    logic [3:0][W:0]    f_v;
    lane_tag_t [3:0]    f_tag;

    // per-lane results after the divider and after the root extractor
    logic [3:0]         d_valid;
    lane_tag_t [3:0]    d_tag;
    logic [3:0][2*W:0]  d_q;
    logic [3:0]         r_valid;
    lane_tag_t [3:0]    r_tag;
    logic [3:0][W:0]    r_root;

    logic [3:0][W-1:0]  comp_next;
    logic [3:0][W-1:0]  comp_reg;
    logic               done_reg;
    logic               degen_reg;

    // no backpressure anywhere in the pipe
    assign busy = 1'b0;

    rmq_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .e00       (e00),
        .e01       (e01),
        .e02       (e02),
        .e10       (e10),
        .e11       (e11),
        .e12       (e12),
        .e20       (e20),
        .e21       (e21),
        .e22       (e22),
        .out_valid (f_valid),
        .s_out     (f_s),
        .v_out     (f_v),
        .tag_out   (f_tag)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        rmq_div #(.W(W)) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (f_valid),
            .in_tag    (f_tag[i]),
            .v         (f_v[i]),
            .s         (f_s),
            .out_valid (d_valid[i]),
            .out_tag   (d_tag[i]),
            .q         (d_q[i])
        );

        rmq_sqrt #(.W(W)) u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d_valid[i]),
            .in_tag    (d_tag[i]),
            .x         (d_q[i]),
            .out_valid (r_valid[i]),
            .out_tag   (r_tag[i]),
            .root      (r_root[i])
        );
    end

    // round half up on the root, zero for a degenerate lane, else saturate by sign
    always_comb
    begin
        logic [W+1:0] sum;
        logic [W:0]   m;
        logic [W:0]   neg_m;
        for (int i = 0; i < 4; i++)
        begin
            sum   = {1'b0, r_root[i]} + (W+2)'(1);
            m     = sum[W+1:1];
            neg_m = -m;
            if (r_tag[i].flag)
            begin
                comp_next[i] = '0;
            end
            else if (!r_tag[i].neg)
            begin
                comp_next[i] = (m > POS_MAX) ? POS_MAX[W-1:0] : m[W-1:0];
            end
            else
            begin
                comp_next[i] = (m >= NEG_MAX) ? NEG_MAX[W-1:0] : neg_m[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= &r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        comp_reg  <= comp_next;
        degen_reg <= r_tag[0].flag;
    end

    assign done       = done_reg;
    assign quat_x     = comp_reg[0];
    assign quat_y     = comp_reg[1];
    assign quat_z     = comp_reg[2];
    assign quat_w     = comp_reg[3];
    assign degenerate = degen_reg;

endmodule

/* verif/rotation_matrix_to_quaternion_tb.sv */
// self-checking testbench for the rotation matrix to quaternion pipeline
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;

    import rmq_pkg::*;

    localparam int W = rmq_pkg::DATA_WIDTH_DEF;
    localparam int FB = W - 2;
    localparam longint QHI = (64'sd1 <<< (W - 1)) - 1;
    localparam longint QLO = -(64'sd1 <<< (W - 1));
    // pipeline depth of the design; the end of the run adds a margin to it
    localparam int LATENCY = 3 * W + 6;
    localparam int STALL_LIMIT = 4000;

    typedef logic signed [W-1:0] elem_t;

    // one expected quaternion word
    typedef struct {
        elem_t qx;
        elem_t qy;
        elem_t qz;
        elem_t qw;
        logic  degen;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    elem_t e00 = '0, e01 = '0, e02 = '0, e10 = '0, e11 = '0;
    elem_t e12 = '0, e20 = '0, e21 = '0, e22 = '0;
    logic done;
    elem_t quat_x, quat_y, quat_z, quat_w;
    logic degenerate;

    quat_t pending_quats[$];
    int errors = 0;
    int idle_cycles = 0;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(W)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .e00(e00), .e01(e01), .e02(e02), .e10(e10), .e11(e11),
        .e12(e12), .e20(e20), .e21(e21), .e22(e22),
        .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .quat_w(quat_w), .degenerate(degenerate)
    );

    always #2 clk = ~clk;

    // clamp to the output code range
    function automatic elem_t clamp(input longint v);
        if (v > QHI) return elem_t'(QHI);
        if (v < QLO) return elem_t'(QLO);
        return elem_t'(v);
    endfunction

    // integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // round(sqrt(s)/2) in output units
    function automatic elem_t major_comp(input longint s);
        longint unsigned k;
        k = int_sqrt(longint'(s) << FB);
        return clamp(longint'((k + 1) >> 1));
    endfunction

    // round(p/(2*sqrt(s))), ties away from zero, by search on the square
    function automatic elem_t pair_comp(input longint p, input longint s);
        longint unsigned ap, rhs, lo, hi, mid, t;
        ap = (p < 0) ? longint'(-p) : longint'(p);
        rhs = (ap * ap) << FB;
        lo = 0;
        hi = 64'd1 << (FB + 1);
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * longint'(s) <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return clamp(p < 0 ? -longint'(lo) : longint'(lo));
    endfunction

    // shepperd branch selection and component evaluation
    function automatic quat_t predict_quat(input elem_t m[9]);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one, s, d;
        longint pr[4];
        int dom;
        quat_t q;
        a00 = m[0]; a01 = m[1]; a02 = m[2];
        a10 = m[3]; a11 = m[4]; a12 = m[5];
        a20 = m[6]; a21 = m[7]; a22 = m[8];
        one = 64'sd1 <<< FB;
        pr = '{0, 0, 0, 0};
        if (a22 <= 0) begin
            d = a11 - a00;
            if (d <= 0) begin
                s = one - a22 - d; dom = 0;
                pr[1] = a01 + a10; pr[2] = a02 + a20; pr[3] = a12 - a21;
            end
            else begin
                s = one - a22 + d; dom = 1;
                pr[0] = a01 + a10; pr[2] = a12 + a21; pr[3] = a20 - a02;
            end
        end
        else begin
            d = a11 + a00;
            if (d <= 0) begin
                s = one + a22 - d; dom = 2;
                pr[0] = a02 + a20; pr[1] = a12 + a21; pr[3] = a01 - a10;
            end
            else begin
                s = one + a22 + d; dom = 3;
                pr[0] = a12 - a21; pr[1] = a20 - a02; pr[2] = a01 - a10;
            end
        end
        if (s <= 0) begin
            q = '{qx: '0, qy: '0, qz: '0, qw: '0, degen: 1'b1};
        end
        else begin
            q.degen = 1'b0;
            q.qx = (dom == 0) ? major_comp(s) : pair_comp(pr[0], s);
            q.qy = (dom == 1) ? major_comp(s) : pair_comp(pr[1], s);
            q.qz = (dom == 2) ? major_comp(s) : pair_comp(pr[2], s);
            q.qw = (dom == 3) ? major_comp(s) : pair_comp(pr[3], s);
        end
        return q;
    endfunction

    // present one matrix word after a random gap and wait for it to be taken
    task automatic send_matrix(input elem_t m[9]);
        int gap;
        gap = $urandom_range(0, 7);
        // long runs without gaps too
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        e00 <= m[0]; e01 <= m[1]; e02 <= m[2];
        e10 <= m[3]; e11 <= m[4]; e12 <= m[5];
        e20 <= m[6]; e21 <= m[7]; e22 <= m[8];
        do @(posedge clk); while (busy);
        pending_quats.push_back(predict_quat(m));
    endtask

    task automatic send_fill(input elem_t v);
        elem_t m[9];
        foreach (m[i]) m[i] = v;
        send_matrix(m);
    endtask

    // corners, identity, each dominant branch and the branch boundaries
    task automatic test_directed();
        elem_t m[9];
        elem_t one;
        one = elem_t'(1 << FB);
        send_fill('0);
        send_fill(elem_t'(QHI));
        send_fill(elem_t'(QLO));
        send_fill(elem_t'(-1));
        // identity gives w dominant
        m = '{one, 0, 0, 0, one, 0, 0, 0, one};
        send_matrix(m);
        // 180 degrees about x, y and z
        m = '{one, 0, 0, 0, -one, 0, 0, 0, -one};
        send_matrix(m);
        m = '{-one, 0, 0, 0, one, 0, 0, 0, -one};
        send_matrix(m);
        m = '{-one, 0, 0, 0, -one, 0, 0, 0, one};
        send_matrix(m);
        // e22 zero and e11 equal to e00: boundary of the x branch
        m = '{100, 7, -9, 11, 100, 13, -15, 17, 0};
        send_matrix(m);
        // e22 one above zero and e11+e00 zero
        m = '{300, -5, 6, 7, -300, 8, 9, -10, 1};
        send_matrix(m);
        // large pair sums that saturate the minor components
        m = '{elem_t'(QLO), elem_t'(QHI), elem_t'(QHI), elem_t'(QHI), elem_t'(QLO),
              elem_t'(QHI), elem_t'(QHI), elem_t'(QLO), elem_t'(QLO)};
        send_matrix(m);
        m = '{elem_t'(QHI), elem_t'(QLO), elem_t'(QLO), elem_t'(QLO), elem_t'(QHI),
              elem_t'(QLO), elem_t'(QLO), elem_t'(QHI), elem_t'(QHI)};
        send_matrix(m);
        // small radicand with odd pairs, close to rounding ties
        m = '{one, 1, 3, 2, one, 5, 1, 0, -one};
        send_matrix(m);
        m = '{0, 1, -1, 1, 0, -3, 3, 2, -one};
        send_matrix(m);
    endtask

    // random matrices: random bit patterns, elements within plus or minus one, small values, and one extreme element
    task automatic test_random(input int count);
        elem_t m[9];
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: foreach (m[i]) m[i] = elem_t'($urandom);
                1: foreach (m[i]) m[i] = elem_t'($signed($urandom_range(0, 2 << FB))
                                                  - (1 << FB));
                2: foreach (m[i]) m[i] = elem_t'($signed($urandom_range(0, 64)) - 32);
                default: begin
                    foreach (m[i]) m[i] = elem_t'($urandom);
                    m[$urandom_range(0, 8)] = ($urandom_range(0, 1) != 0) ?
                        elem_t'(QHI) : elem_t'(QLO);
                end
            endcase
            send_matrix(m);
        end
        start <= 1'b0;
    endtask

    // compare every done word with the oldest prediction
    always @(posedge clk) begin
        quat_t q;
        if (done) begin
            if (pending_quats.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d z=%0d w=%0d deg=%0b",
                         $time, quat_x, quat_y, quat_z, quat_w, degenerate);
                errors++;
            end
            else begin
                q = pending_quats.pop_front();
                if (quat_x !== q.qx) begin
                    $display("%0t: quat_x expected %0d actual %0d", $time, q.qx, quat_x);
                    errors++;
                end
                if (quat_y !== q.qy) begin
                    $display("%0t: quat_y expected %0d actual %0d", $time, q.qy, quat_y);
                    errors++;
                end
                if (quat_z !== q.qz) begin
                    $display("%0t: quat_z expected %0d actual %0d", $time, q.qz, quat_z);
                    errors++;
                end
                if (quat_w !== q.qw) begin
                    $display("%0t: quat_w expected %0d actual %0d", $time, q.qw, quat_w);
                    errors++;
                end
                if (degenerate !== q.degen) begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, q.degen, degenerate);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word in either direction
    always @(posedge clk) begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1950);
        while (pending_quats.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
